// File: hdl/nbcps_pkg.sv
// Package for the nuts-and-bolts cross partition sort.
// Holds sizes and the sequencer state type; no dependencies.
package nbcps_pkg;

    localparam int MAX_PAIRS_DEF  = 64;
    localparam int VALUE_BITS_DEF = 32;
    localparam int FIELD_BITS     = 32;
    localparam int POS_BITS       = 6;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_PUSH0,
        ST_POP,
        ST_POPW,
        ST_PIVRD,
        ST_PIVWT,
        ST_SCANRD,
        ST_SCANWT,
        ST_SCANEV,
        ST_SWAPW,
        ST_FINRD,
        ST_FINWT,
        ST_FINWR,
        ST_PUSHL,
        ST_PUSHH,
        ST_EMITRD,
        ST_EMITWT,
        ST_EMIT
    } seq_state_t;

endpackage

// File: hdl/nbcps_store.sv
// Paired dual-port store for nut and bolt values, with registered reads.
// Depends on nbcps_pkg for nothing but the house widths.
module nbcps_store #(
    parameter int DEPTH = nbcps_pkg::MAX_PAIRS_DEF,
    parameter int WIDTH = nbcps_pkg::VALUE_BITS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we_a,
    input  logic [AW-1:0]    addr_a,
    input  logic [WIDTH-1:0] wdata_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic             we_b,
    input  logic [AW-1:0]    addr_b,
    input  logic [WIDTH-1:0] wdata_b,
    output logic [WIDTH-1:0] rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    // port a takes precedence when both ports write the same slot
    always_ff @(posedge aclk) begin
        if (we_a) begin
            mem[addr_a] <= wdata_a;
        end
        if (we_b && !(we_a && addr_a == addr_b)) begin
            mem[addr_b] <= wdata_b;
        end
        rdata_a <= mem[addr_a];
        rdata_b <= mem[addr_b];
    end
endmodule

// File: hdl/nuts_bolts_cross_partition_sort.sv
// Channel  | Ports                                        | Direction
// s_       | s_valid s_ready s_nut_value s_bolt_value s_is_last | in
// m_       | m_valid m_ready m_position m_nut_out m_bolt_out m_unmatched
//          | m_overflowed m_last_result                  | out
// Loading takes one cycle a pair. After the last pair the sequencer sorts each
// scanned element by a read, a wait and a compare, with a swap step when the element
// moves below the split point; the scan is quadratic in the worst case.
// Emission steps through a read, a wait and an emit for each pair.
// No input is taken while sorting or emitting; m_ready low holds the result.
// aresetn is synchronous, active low; the stores need no clearing.
// Depends on nbcps_pkg and nbcps_store.
module nuts_bolts_cross_partition_sort #(
    parameter int MAX_PAIRS  = nbcps_pkg::MAX_PAIRS_DEF,
    parameter int VALUE_BITS = nbcps_pkg::VALUE_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [nbcps_pkg::FIELD_BITS-1:0] s_nut_value,
    input  logic signed [nbcps_pkg::FIELD_BITS-1:0] s_bolt_value,
    input  logic                                    s_is_last,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [nbcps_pkg::POS_BITS-1:0]          m_position,
    output logic signed [nbcps_pkg::FIELD_BITS-1:0] m_nut_out,
    output logic signed [nbcps_pkg::FIELD_BITS-1:0] m_bolt_out,
    output logic                                    m_unmatched,
    output logic                                    m_overflowed,
    output logic                                    m_last_result
);
    localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int CW = $clog2(MAX_PAIRS + 1);
    localparam int FB = nbcps_pkg::FIELD_BITS;
    localparam int PB = nbcps_pkg::POS_BITS;

    nbcps_pkg::seq_state_t state_reg, state_next;

    logic [CW-1:0]  count_reg, count_next;
    logic           ovf_reg, ovf_next;
    logic [CW-1:0]  sp_reg, sp_next;
    logic [AW-1:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic [AW-1:0]  scan_reg, scan_next, place_reg, place_next, mid_reg, mid_next;
    logic           phase_reg, phase_next;     // 0 bolts, 1 nuts
    logic [VALUE_BITS-1:0] piv_reg, piv_next, top_reg, top_next, cur_reg, cur_next;
    logic [CW-1:0]  idx_reg, idx_next;

    // stack memory
    logic [2*AW-1:0] stack_mem [MAX_PAIRS];
    logic [2*AW-1:0] stack_rd;
    logic            stk_we;
    logic [AW-1:0]   stk_waddr, stk_raddr;
    logic [2*AW-1:0] stk_wdata;

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        stack_rd <= stack_mem[stk_raddr];
    end

    // store ports: bolts are unit 0, nuts unit 1
    logic                  nwe_a, nwe_b, bwe_a, bwe_b;
    logic [AW-1:0]         addr_a, addr_b;
    logic [VALUE_BITS-1:0] nwd_a, nwd_b, bwd_a, bwd_b;
    logic [VALUE_BITS-1:0] nrd_a, nrd_b, brd_a, brd_b;

    nbcps_store #(.DEPTH(MAX_PAIRS), .WIDTH(VALUE_BITS), .AW(AW)) u_nut (
        .aclk(aclk), .we_a(nwe_a), .addr_a(addr_a), .wdata_a(nwd_a), .rdata_a(nrd_a),
        .we_b(nwe_b), .addr_b(addr_b), .wdata_b(nwd_b), .rdata_b(nrd_b));
    nbcps_store #(.DEPTH(MAX_PAIRS), .WIDTH(VALUE_BITS), .AW(AW)) u_bolt (
        .aclk(aclk), .we_a(bwe_a), .addr_a(addr_a), .wdata_a(bwd_a), .rdata_a(brd_a),
        .we_b(bwe_b), .addr_b(addr_b), .wdata_b(bwd_b), .rdata_b(brd_b));

    logic [VALUE_BITS-1:0] rd_a, rd_b, nut_in, bolt_in;
    logic [VALUE_BITS-1:0] out_nut_reg, out_bolt_reg;
    logic [PB-1:0]         out_pos_reg;
    logic                  out_last_reg, out_ovf_reg, m_valid_reg;

    always_comb begin
        rd_a = phase_reg ? nrd_a : brd_a;
        rd_b = phase_reg ? nrd_b : brd_b;
        // sign-extend or truncate to the stored width
        nut_in  = VALUE_BITS'(s_nut_value);
        bolt_in = VALUE_BITS'(s_bolt_value);
    end

    function automatic logic [FB-1:0] to_field(input logic [VALUE_BITS-1:0] v);
        logic signed [VALUE_BITS-1:0] sv;
        sv = v;
        to_field = FB'(sv);
    endfunction

    logic signed [VALUE_BITS-1:0] cur_s, piv_s, top_s;
    assign cur_s = cur_reg;
    assign piv_s = piv_reg;
    assign top_s = top_reg;

    assign s_ready = (state_reg == nbcps_pkg::ST_LOAD);
    assign m_valid = m_valid_reg;
    assign m_position    = out_pos_reg;
    assign m_nut_out     = to_field(out_nut_reg);
    assign m_bolt_out    = to_field(out_bolt_reg);
    assign m_unmatched   = (out_nut_reg != out_bolt_reg);
    assign m_overflowed  = out_ovf_reg;
    assign m_last_result = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= nbcps_pkg::ST_LOAD;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            sp_reg    <= sp_next;
            if (state_reg == nbcps_pkg::ST_EMITWT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg <= lo_next;  hi_reg <= hi_next;
        scan_reg <= scan_next; place_reg <= place_next; mid_reg <= mid_next;
        phase_reg <= phase_next; piv_reg <= piv_next; top_reg <= top_next;
        cur_reg <= cur_next; idx_reg <= idx_next;
        if (state_reg == nbcps_pkg::ST_EMITWT) begin
            out_nut_reg  <= nrd_a;
            out_bolt_reg <= brd_a;
            out_pos_reg  <= PB'(idx_reg);
            out_last_reg <= (idx_reg + CW'(1) == count_reg);
            out_ovf_reg  <= ovf_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg; ovf_next = ovf_reg; sp_next = sp_reg;
        lo_next = lo_reg; hi_next = hi_reg; scan_next = scan_reg;
        place_next = place_reg; mid_next = mid_reg; phase_next = phase_reg;
        piv_next = piv_reg; top_next = top_reg; cur_next = cur_reg; idx_next = idx_reg;
        stk_we = 1'b0; stk_waddr = '0; stk_wdata = '0;
        stk_raddr = AW'(sp_reg - CW'(1));
        nwe_a = 1'b0; nwe_b = 1'b0; bwe_a = 1'b0; bwe_b = 1'b0;
        addr_a = AW'(count_reg); addr_b = hi_reg;
        nwd_a = nut_in; bwd_a = bolt_in; nwd_b = '0; bwd_b = '0;

        unique case (state_reg)
            nbcps_pkg::ST_LOAD: begin
                if (s_valid) begin
                    if (count_reg < CW'(MAX_PAIRS)) begin
                        nwe_a = 1'b1; bwe_a = 1'b1;
                        count_next = count_reg + CW'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_is_last) begin
                        state_next = nbcps_pkg::ST_PUSH0;
                    end
                end
            end
            nbcps_pkg::ST_PUSH0: begin
                sp_next = '0;
                if (count_reg >= CW'(2)) begin
                    stk_we = 1'b1; stk_waddr = '0;
                    stk_wdata = {AW'(0), AW'(count_reg - CW'(1))};
                    sp_next = CW'(1);
                end
                state_next = nbcps_pkg::ST_POP;
            end
            nbcps_pkg::ST_POP: begin
                if (sp_reg == '0) begin
                    idx_next = '0;
                    state_next = (count_reg == '0) ? nbcps_pkg::ST_LOAD
                                                   : nbcps_pkg::ST_EMITRD;
                    if (count_reg == '0) begin
                        ovf_next = 1'b0;
                    end
                end else begin
                    sp_next = sp_reg - CW'(1);
                    state_next = nbcps_pkg::ST_POPW;
                end
            end
            nbcps_pkg::ST_POPW: begin
                lo_next = stack_rd[2*AW-1:AW];
                hi_next = stack_rd[AW-1:0];
                phase_next = 1'b0;
                state_next = (stack_rd[2*AW-1:AW] >= stack_rd[AW-1:0])
                           ? nbcps_pkg::ST_POP : nbcps_pkg::ST_PIVRD;
            end
            nbcps_pkg::ST_PIVRD: begin
                addr_b = hi_reg;
                state_next = nbcps_pkg::ST_PIVWT;
            end
            nbcps_pkg::ST_PIVWT: begin
                // bolts take the top nut as pivot
                piv_next = nrd_b;
                scan_next = lo_reg; place_next = lo_reg;
                state_next = nbcps_pkg::ST_SCANRD;
            end
            nbcps_pkg::ST_SCANRD: begin
                addr_a = scan_reg; addr_b = hi_reg;
                state_next = (scan_reg < hi_reg) ? nbcps_pkg::ST_SCANWT
                                                 : nbcps_pkg::ST_FINRD;
            end
            nbcps_pkg::ST_SCANWT: begin
                cur_next = rd_a; top_next = rd_b;
                state_next = nbcps_pkg::ST_SCANEV;
            end
            nbcps_pkg::ST_SCANEV: begin
                if (cur_s < piv_s) begin
                    addr_a = scan_reg; addr_b = place_reg;
                    state_next = nbcps_pkg::ST_SWAPW;
                end else if (cur_s == piv_s && top_s != piv_s) begin
                    // swap with the top, recheck the same slot
                    addr_a = scan_reg; addr_b = hi_reg;
                    if (phase_reg) begin
                        nwe_a = 1'b1; nwd_a = top_reg; nwe_b = 1'b1; nwd_b = cur_reg;
                    end else begin
                        bwe_a = 1'b1; bwd_a = top_reg; bwe_b = 1'b1; bwd_b = cur_reg;
                    end
                    state_next = nbcps_pkg::ST_SCANRD;
                end else begin
                    scan_next = scan_reg + AW'(1);
                    state_next = nbcps_pkg::ST_SCANRD;
                end
            end
            nbcps_pkg::ST_SWAPW: begin
                // port b read the place slot last cycle; same slot needs no write
                addr_a = scan_reg; addr_b = place_reg;
                if (scan_reg != place_reg) begin
                    if (phase_reg) begin
                        nwe_a = 1'b1; nwd_a = rd_b; nwe_b = 1'b1; nwd_b = cur_reg;
                    end else begin
                        bwe_a = 1'b1; bwd_a = rd_b; bwe_b = 1'b1; bwd_b = cur_reg;
                    end
                end
                scan_next = scan_reg + AW'(1);
                place_next = place_reg + AW'(1);
                state_next = nbcps_pkg::ST_SCANRD;
            end
            nbcps_pkg::ST_FINRD: begin
                addr_a = place_reg; addr_b = hi_reg;
                state_next = nbcps_pkg::ST_FINWT;
            end
            nbcps_pkg::ST_FINWT: begin
                cur_next = rd_a; top_next = rd_b;
                state_next = nbcps_pkg::ST_FINWR;
            end
            nbcps_pkg::ST_FINWR: begin
                addr_a = place_reg; addr_b = hi_reg;
                if (phase_reg) begin
                    nwe_b = 1'b1; nwd_b = cur_reg; nwe_a = 1'b1; nwd_a = top_reg;
                    state_next = nbcps_pkg::ST_PUSHL;
                end else begin
                    bwe_b = 1'b1; bwd_b = cur_reg; bwe_a = 1'b1; bwd_a = top_reg;
                    // nuts take the bolt now at the split point
                    mid_next = place_reg;
                    piv_next = top_reg;
                    phase_next = 1'b1;
                    scan_next = lo_reg; place_next = lo_reg;
                    state_next = nbcps_pkg::ST_SCANRD;
                end
                if (place_reg == hi_reg) begin
                    // same slot on both ports: keep one write
                    nwe_b = 1'b0; bwe_b = 1'b0;
                end
            end
            nbcps_pkg::ST_PUSHL: begin
                if (mid_reg > lo_reg + AW'(1) && sp_reg < CW'(MAX_PAIRS)) begin
                    stk_we = 1'b1; stk_waddr = AW'(sp_reg);
                    stk_wdata = {lo_reg, mid_reg - AW'(1)};
                    sp_next = sp_reg + CW'(1);
                end
                state_next = nbcps_pkg::ST_PUSHH;
            end
            nbcps_pkg::ST_PUSHH: begin
                if ({1'b0, mid_reg} + (AW+1)'(1) < {1'b0, hi_reg} &&
                    sp_reg < CW'(MAX_PAIRS)) begin
                    stk_we = 1'b1; stk_waddr = AW'(sp_reg);
                    stk_wdata = {mid_reg + AW'(1), hi_reg};
                    sp_next = sp_reg + CW'(1);
                end
                state_next = nbcps_pkg::ST_POP;
            end
            nbcps_pkg::ST_EMITRD: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = nbcps_pkg::ST_EMITWT;
                end
                addr_a = AW'(idx_reg);
            end
            nbcps_pkg::ST_EMITWT: begin
                addr_a = AW'(idx_reg);
                state_next = nbcps_pkg::ST_EMIT;
            end
            nbcps_pkg::ST_EMIT: begin
                idx_next = idx_reg + CW'(1);
                if (idx_reg + CW'(1) == count_reg) begin
                    count_next = '0;
                    ovf_next = 1'b0;
                    state_next = nbcps_pkg::ST_LOAD;
                end else begin
                    state_next = nbcps_pkg::ST_EMITRD;
                end
            end
            default: state_next = nbcps_pkg::ST_LOAD;
        endcase
    end
endmodule
